### hw/rtl/assert_macros.svh
// assertion macros shared by the deframer rtl
// no dependencies; define ASSERT_OFF to drop every check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property holds at every rising clock edge outside reset
`define SWLD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("swld assertion failed");
// condition never holds outside reset
`define SWLD_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("swld forbidden condition seen");
`else
`define SWLD_ASSERT(lbl, clk, rstn, prop)
`define SWLD_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

### hw/rtl/swld_pkg.sv
// types and constants of the sync word length deframer
// no dependencies; used by the frame interface and every module
`timescale 1ns / 1ps

package swld_pkg;

    localparam logic [7:0]  SYNC_FIRST  = 8'h54;
    localparam logic [7:0]  SYNC_SECOND = 8'h42;
    localparam logic [31:0] MAX_LENGTH  = 32'd4096;
    localparam int          LENGTH_W    = 13;
    localparam int          OUT_LEN_W   = 9;

    // registered input byte handed from the input stage to the parser
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } rx_stage_t;

    // one result item as held in the output register
    typedef struct packed {
        logic                 valid;
        logic [7:0]           frame_cmd;
        logic [31:0]          frame_sender;
        logic [OUT_LEN_W-1:0] frame_length;
        logic [7:0]           data_byte;
        logic                 data_valid;
        logic                 last;
    } result_t;

endpackage

### hw/rtl/swld_rx_if.sv
// byte channel into the deframer
// depends on nothing
`timescale 1ns / 1ps

interface swld_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

### hw/rtl/swld_frame_if.sv
// result channel out of the deframer
// depends on swld_pkg for the length width
`timescale 1ns / 1ps

interface swld_frame_if;
    logic                           valid;
    logic                           ready;
    logic [7:0]                     frame_cmd;
    logic [31:0]                    frame_sender;
    logic [swld_pkg::OUT_LEN_W-1:0] frame_length;
    logic [7:0]                     data_byte;
    logic                           data_valid;
    logic                           last;

    modport source (output valid, output frame_cmd, output frame_sender,
                    output frame_length, output data_byte, output data_valid,
                    output last, input ready);
    modport sink (input valid, input frame_cmd, input frame_sender,
                  input frame_length, input data_byte, input data_valid,
                  input last, output ready);
endinterface

### hw/rtl/swld_rx_stage.sv
// input register of the deframer: holds one received byte for the parser
// depends on swld_pkg
`timescale 1ns / 1ps

module swld_rx_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rx_valid,
    input  logic [7:0]          rx_byte,
    output logic                rx_ready,
    input  logic                take,
    output swld_pkg::rx_stage_t stage
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic [7:0] data_next;

    // accept while empty or while the held byte moves on this cycle
    assign rx_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (rx_ready)
        begin
            valid_next = rx_valid;
            if (rx_valid)
            begin
                data_next = rx_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign stage.valid = valid_reg;
    assign stage.data  = data_reg;

endmodule

### hw/rtl/swld_parser.sv
// header window, frame state and output register of the deframer
// depends on swld_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module swld_parser
#(
    parameter int HEADER_BYTES = 24,
    parameter int BUFFER_BYTES = 512
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  swld_pkg::rx_stage_t stage,
    output logic                take,
    input  logic                out_ready,
    output swld_pkg::result_t   result
);

    localparam int FW    = $clog2(BUFFER_BYTES + 1);
    localparam int LW    = swld_pkg::LENGTH_W;
    localparam int CMP_W = ((FW > LW) ? FW : LW) + 1;

    localparam logic [FW-1:0]    HB_F    = FW'(HEADER_BYTES);
    localparam logic [FW-1:0]    HB_M1_F = FW'(HEADER_BYTES - 1);
    localparam logic [FW-1:0]    BB_F    = FW'(BUFFER_BYTES);
    localparam logic [CMP_W-1:0] HB_C    = CMP_W'(HEADER_BYTES);
    localparam logic [CMP_W-1:0] BB_C    = CMP_W'(BUFFER_BYTES);

    logic [7:0]        win_reg  [HEADER_BYTES];
    logic [7:0]        win_next [HEADER_BYTES];
    logic [FW-1:0]     fill_reg;
    logic [FW-1:0]     fill_next;
    logic              in_payload_reg;
    logic              in_payload_next;
    logic              oversize_reg;
    logic              oversize_next;
    logic [7:0]        cmd_reg;
    logic [7:0]        cmd_next;
    logic [31:0]       sender_reg;
    logic [31:0]       sender_next;
    logic [LW-1:0]     len_reg;
    logic [LW-1:0]     len_next;
    swld_pkg::result_t out_reg;
    swld_pkg::result_t out_next;

    logic [7:0]        b;
    logic [FW-1:0]     fill_inc;
    logic [FW-1:0]     pos;
    logic [FW-1:0]     pos_inc;
    logic              go_on;
    logic              sync_ok;
    logic [31:0]       hdr_len;
    logic              len_bad;

    assign take = stage.valid && (!out_reg.valid || out_ready);
    assign b    = stage.data;

    assign fill_inc = fill_reg + FW'(1);
    assign sync_ok  = (win_reg[0] == swld_pkg::SYNC_FIRST) &&
                      (win_reg[1] == swld_pkg::SYNC_SECOND);
    // with a 16-byte header the incoming byte is the last length byte
    assign hdr_len  = {win_reg[12], win_reg[13], win_reg[14],
                       (HEADER_BYTES == 16) ? b : win_reg[15]};
    assign len_bad  = hdr_len[31] || (hdr_len > swld_pkg::MAX_LENGTH);

    always_comb
    begin
        win_next        = win_reg;
        fill_next       = fill_reg;
        in_payload_next = in_payload_reg;
        oversize_next   = oversize_reg;
        cmd_next        = cmd_reg;
        sender_next     = sender_reg;
        len_next        = len_reg;
        out_next        = out_reg;
        out_next.valid  = out_reg.valid && !out_ready;
        pos             = fill_reg;
        go_on           = 1'b0;

        if (take)
        begin
            if (in_payload_reg)
            begin
                fill_next              = fill_inc;
                out_next.valid         = 1'b1;
                out_next.frame_cmd     = cmd_reg;
                out_next.frame_sender  = sender_reg;
                out_next.frame_length  = len_reg[swld_pkg::OUT_LEN_W-1:0];
                out_next.data_byte     = b;
                out_next.data_valid    = 1'b1;
                out_next.last          = CMP_W'(fill_inc) >= (HB_C + CMP_W'(len_reg));
                if (out_next.last)
                begin
                    in_payload_next = 1'b0;
                    fill_next       = '0;
                end
            end
            else if (oversize_reg)
            begin
                if (fill_reg < BB_F)
                begin
                    fill_next = fill_inc;
                end
                else
                begin
                    // discard finished: this byte opens a new window
                    oversize_next = 1'b0;
                    pos           = '0;
                    go_on         = 1'b1;
                end
            end
            else
            begin
                go_on = 1'b1;
                if (fill_reg >= HB_F)
                begin
                    pos = '0;
                end
            end
        end

        pos_inc = pos + FW'(1);

        if (go_on)
        begin
            for (int i = 0; i < HEADER_BYTES; i++)
            begin
                if (pos == FW'(i))
                begin
                    win_next[i] = b;
                end
            end
            fill_next = pos_inc;
            if (pos_inc >= HB_F)
            begin
                if (!sync_ok)
                begin
                    // slide the window by one byte and keep searching
                    for (int i = 0; i < HEADER_BYTES - 2; i++)
                    begin
                        win_next[i] = win_reg[i + 1];
                    end
                    win_next[HEADER_BYTES-2] = b;
                    win_next[HEADER_BYTES-1] = '0;
                    fill_next                = HB_M1_F;
                end
                else if (len_bad)
                begin
                    fill_next = '0;
                end
                else
                begin
                    cmd_next    = win_reg[3];
                    sender_next = {win_reg[4], win_reg[5], win_reg[6], win_reg[7]};
                    len_next    = hdr_len[LW-1:0];
                    if (hdr_len[LW-1:0] == '0)
                    begin
                        // empty frame gives a single marker transfer
                        fill_next             = '0;
                        out_next.valid        = 1'b1;
                        out_next.frame_cmd    = win_reg[3];
                        out_next.frame_sender = {win_reg[4], win_reg[5],
                                                 win_reg[6], win_reg[7]};
                        out_next.frame_length = '0;
                        out_next.data_byte    = '0;
                        out_next.data_valid   = 1'b0;
                        out_next.last         = 1'b1;
                    end
                    else if ((HB_C + CMP_W'(hdr_len[LW-1:0])) > BB_C)
                    begin
                        oversize_next = 1'b1;
                    end
                    else
                    begin
                        in_payload_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HEADER_BYTES; i++)
            begin
                win_reg[i] <= '0;
            end
            fill_reg       <= '0;
            in_payload_reg <= 1'b0;
            oversize_reg   <= 1'b0;
            cmd_reg        <= '0;
            sender_reg     <= '0;
            len_reg        <= '0;
            out_reg        <= '0;
        end
        else
        begin
            win_reg        <= win_next;
            fill_reg       <= fill_next;
            in_payload_reg <= in_payload_next;
            oversize_reg   <= oversize_next;
            cmd_reg        <= cmd_next;
            sender_reg     <= sender_next;
            len_reg        <= len_next;
            out_reg        <= out_next;
        end
    end

    assign result = out_reg;

    `SWLD_ASSERT_NEVER(a_payload_and_discard, clk, rst_n, in_payload_reg && oversize_reg)
    `SWLD_ASSERT(a_payload_fill, clk, rst_n, in_payload_reg |-> (fill_reg >= HB_F))
    `SWLD_ASSERT(a_hunt_fill, clk, rst_n, (!in_payload_reg && !oversize_reg) |-> (fill_reg < HB_F))
    `SWLD_ASSERT(a_payload_emits, clk, rst_n, (take && in_payload_reg) |=> out_reg.valid)

endmodule

### hw/rtl/sync_word_length_deframer_core.sv
// top level of the sync word length deframer
// depends on swld_pkg, swld_rx_if, swld_frame_if, swld_rx_stage, swld_parser
`timescale 1ns / 1ps

// usage
//   rx carries one raw byte per transfer; frame carries one result per transfer.
//   each accepted byte is parsed against a header window of HEADER_BYTES bytes;
//   a frame starts with 0x54 0x42, its big-endian length sits in bytes 12..15.
//   after a good header every payload byte leaves as one transfer with the
//   latched command, sender and length; last marks the final byte. an empty
//   frame gives one transfer with data_valid low and last high.
//   a frame over BUFFER_BYTES in total: its first BUFFER_BYTES bytes give no output.
// timing
//   one byte per cycle sustained while frame.ready stays high. a byte is held in
//   the input register until the parser takes it, then is parsed into the output
//   register, which offers its result.
//   while frame.ready is low the output register holds its result and the
//   input register still takes one more byte; rx.ready then drops.
// reset
//   rst_n clears the window, the fill count, the input valid flag and frame.valid at once;
//   the block is ready right after reset.

module sync_word_length_deframer_core
#(
    parameter int HEADER_BYTES = 24,
    parameter int BUFFER_BYTES = 512
)
(
    input  logic         clk,
    input  logic         rst_n,
    swld_rx_if.sink      rx,
    swld_frame_if.source frame
);

    swld_pkg::rx_stage_t stage;
    swld_pkg::result_t   result;
    logic                take;

    swld_rx_stage u_rx_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx.valid),
        .rx_byte  (rx.rx_byte),
        .rx_ready (rx.ready),
        .take     (take),
        .stage    (stage)
    );

    swld_parser
    #(
        .HEADER_BYTES (HEADER_BYTES),
        .BUFFER_BYTES (BUFFER_BYTES)
    )
    u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage     (stage),
        .take      (take),
        .out_ready (frame.ready),
        .result    (result)
    );

    assign frame.valid        = result.valid;
    assign frame.frame_cmd    = result.frame_cmd;
    assign frame.frame_sender = result.frame_sender;
    assign frame.frame_length = result.frame_length;
    assign frame.data_byte    = result.data_byte;
    assign frame.data_valid   = result.data_valid;
    assign frame.last         = result.last;

endmodule

### tb/swld_frame_checker.sv
// checker for the sync word length deframer: tracks the header window on every byte transfer,
// queues the results it expects and compares each result transfer against the oldest one
// depends on swld_pkg, swld_rx_if and swld_frame_if
`timescale 1ns / 1ps

module swld_frame_checker
#(
    parameter int HEADER_BYTES = 24,
    parameter int BUFFER_BYTES = 512
)
(
    input  logic  clk,
    input  logic  rst_n,
    swld_rx_if    rx,
    swld_frame_if frame,
    output int    mismatches,
    output int    results_due,
    output int    results_seen,
    output int    empty_frames,
    output int    frames_done,
    output int    resyncs,
    output int    bad_lengths,
    output int    oversize_frames
);

    logic [7:0]                    window [HEADER_BYTES];
    int                            fill;
    bit                            in_frame;
    bit                            discarding;
    logic [7:0]                    cmd_hold;
    logic [31:0]                   sender_hold;
    logic [swld_pkg::LENGTH_W-1:0] length_hold;
    swld_pkg::result_t             beats_due [$];

    int err_cnt;
    int seen_cnt;
    int empty_cnt;
    int done_cnt;
    int resync_cnt;
    int badlen_cnt;
    int over_cnt;

    function automatic swld_pkg::result_t make_beat(input logic [7:0] d, input logic dv,
                                                    input logic lst);
        swld_pkg::result_t r;
        r.valid        = 1'b1;
        r.frame_cmd    = cmd_hold;
        r.frame_sender = sender_hold;
        r.frame_length = length_hold[swld_pkg::OUT_LEN_W-1:0];
        r.data_byte    = d;
        r.data_valid   = dv;
        r.last         = lst;
        return r;
    endfunction

    // appends one expected result at the tail of the queue
    task automatic queue_beat(input swld_pkg::result_t r);
        beats_due = {beats_due, r};
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        logic [31:0] len;
        bit          to_window;
        bit          done;
        to_window = 1'b1;
        if (in_frame)
        begin
            fill++;
            done = (fill >= HEADER_BYTES + length_hold);
            queue_beat(make_beat(b, 1'b1, done));
            if (done)
            begin
                in_frame = 1'b0;
                fill     = 0;
                done_cnt++;
            end
            to_window = 1'b0;
        end
        else if (discarding)
        begin
            // oversize frame: count bytes up to the buffer size, the next one restarts
            if (fill < BUFFER_BYTES)
            begin
                fill++;
                to_window = 1'b0;
            end
            else
            begin
                discarding = 1'b0;
                fill       = 0;
            end
        end
        if (to_window)
        begin
            if (fill >= HEADER_BYTES)
                fill = 0;
            window[fill] = b;
            fill++;
            if (fill >= HEADER_BYTES)
            begin
                if (window[0] != swld_pkg::SYNC_FIRST || window[1] != swld_pkg::SYNC_SECOND)
                begin
                    for (int i = 0; i < HEADER_BYTES - 1; i++)
                        window[i] = window[i+1];
                    window[HEADER_BYTES-1] = 8'h00;
                    fill = HEADER_BYTES - 1;
                    resync_cnt++;
                end
                else
                begin
                    len = {window[12], window[13], window[14], window[15]};
                    if (len[31] || len > swld_pkg::MAX_LENGTH)
                    begin
                        fill = 0;
                        badlen_cnt++;
                    end
                    else
                    begin
                        cmd_hold    = window[3];
                        sender_hold = {window[4], window[5], window[6], window[7]};
                        length_hold = len[swld_pkg::LENGTH_W-1:0];
                        if (len == 0)
                        begin
                            fill = 0;
                            queue_beat(make_beat(8'h00, 1'b0, 1'b1));
                            empty_cnt++;
                            done_cnt++;
                        end
                        else if (HEADER_BYTES + len > BUFFER_BYTES)
                        begin
                            discarding = 1'b1;
                            over_cnt++;
                        end
                        else
                            in_frame = 1'b1;
                    end
                end
            end
        end
    endtask

    task automatic check_beat();
        swld_pkg::result_t want;
        seen_cnt++;
        if (beats_due.size() == 0)
        begin
            err_cnt++;
            if (err_cnt <= 10)
                $display({"[%0t] result with nothing expected: ",
                          "cmd %h sender %h len %0d data %h dv %b last %b"},
                         $realtime, frame.frame_cmd, frame.frame_sender, frame.frame_length,
                         frame.data_byte, frame.data_valid, frame.last);
        end
        else
        begin
            want = beats_due.pop_front();
            if (frame.frame_cmd !== want.frame_cmd || frame.frame_sender !== want.frame_sender ||
                frame.frame_length !== want.frame_length || frame.data_byte !== want.data_byte ||
                frame.data_valid !== want.data_valid || frame.last !== want.last)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                begin
                    $display("[%0t] result %0d mismatch", $realtime, seen_cnt);
                    $display("    expected cmd %h sender %h len %0d data %h dv %b last %b",
                             want.frame_cmd, want.frame_sender, want.frame_length,
                             want.data_byte, want.data_valid, want.last);
                    $display("    actual   cmd %h sender %h len %0d data %h dv %b last %b",
                             frame.frame_cmd, frame.frame_sender, frame.frame_length,
                             frame.data_byte, frame.data_valid, frame.last);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HEADER_BYTES; i++)
                window[i] = 8'h00;
            fill        = 0;
            in_frame    = 1'b0;
            discarding  = 1'b0;
            cmd_hold    = '0;
            sender_hold = '0;
            length_hold = '0;
            beats_due.delete();
            err_cnt     = 0;
            seen_cnt    = 0;
            empty_cnt   = 0;
            done_cnt    = 0;
            resync_cnt  = 0;
            badlen_cnt  = 0;
            over_cnt    = 0;
            mismatches      <= 0;
            results_due     <= 0;
            results_seen    <= 0;
            empty_frames    <= 0;
            frames_done     <= 0;
            resyncs         <= 0;
            bad_lengths     <= 0;
            oversize_frames <= 0;
        end
        else
        begin
            // a result never leaves in the cycle its byte arrives, so compare first
            if (frame.valid && frame.ready)
                check_beat();
            if (rx.valid && rx.ready)
                absorb_byte(rx.rx_byte);
            mismatches      <= err_cnt;
            results_due     <= beats_due.size();
            results_seen    <= seen_cnt;
            empty_frames    <= empty_cnt;
            frames_done     <= done_cnt;
            resyncs         <= resync_cnt;
            bad_lengths     <= badlen_cnt;
            oversize_frames <= over_cnt;
        end
    end

endmodule

### tb/sync_word_length_deframer_core_tb.sv
// top of the deframer testbench: drives framed byte streams, noise and broken headers
// into the block with random bursts and output stalls; depends on swld_pkg, both channel
// interfaces, sync_word_length_deframer_core and swld_frame_checker
`timescale 1ns / 1ps

module sync_word_length_deframer_core_tb;

    localparam int HDR        = 24;
    localparam int BUF        = 512;
    localparam int ITEMS      = 1050;
    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL       = 16;
    localparam int LONG_HOLD  = 150;

    logic clk;
    logic rst_n;

    swld_rx_if    rx_ch ();
    swld_frame_if frame_ch ();

    int burst_left;
    int bytes_sent;
    int stall_cycles;
    bit hold_req;

    int mismatches;
    int results_due;
    int results_seen;
    int empty_frames;
    int frames_done;
    int resyncs;
    int bad_lengths;
    int oversize_frames;

    sync_word_length_deframer_core #(
        .HEADER_BYTES (HDR),
        .BUFFER_BYTES (BUF)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .frame (frame_ch)
    );

    swld_frame_checker #(
        .HEADER_BYTES (HDR),
        .BUFFER_BYTES (BUF)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .rx              (rx_ch),
        .frame           (frame_ch),
        .mismatches      (mismatches),
        .results_due     (results_due),
        .results_seen    (results_seen),
        .empty_frames    (empty_frames),
        .frames_done     (frames_done),
        .resyncs         (resyncs),
        .bad_lengths     (bad_lengths),
        .oversize_frames (oversize_frames)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // one byte per call; ends a burst with a random gap, sometimes none
    task automatic send_byte(input logic [7:0] b);
        int gap;
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        bytes_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                rx_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 32);
        end
    endtask

    task automatic send_frame(input logic [7:0] cmd, input logic [31:0] sender,
                              input logic [31:0] len_field, input int body);
        logic [7:0] head [HDR];
        for (int i = 0; i < HDR; i++)
            head[i] = 8'($urandom_range(0, 255));
        head[0] = swld_pkg::SYNC_FIRST;
        head[1] = swld_pkg::SYNC_SECOND;
        head[3] = cmd;
        {head[4], head[5], head[6], head[7]}     = sender;
        {head[12], head[13], head[14], head[15]} = len_field;
        for (int i = 0; i < HDR; i++)
            send_byte(head[i]);
        for (int i = 0; i < body; i++)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    // sender idles until every expected result has been taken
    task automatic drain_results();
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        burst_left = $urandom_range(1, 32);
    endtask

    // receiver: random stall patterns, plus one long hold-off on request
    initial
    begin
        int mode;
        int span;
        frame_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                frame_ch.ready <= 1'b0;
                hold_req       <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(10, 120);
                repeat (span)
                begin
                    case (mode)
                        0: frame_ch.ready <= 1'b1;
                        1: frame_ch.ready <= ($urandom_range(0, 3) != 0);
                        2: frame_ch.ready <= !frame_ch.ready;
                        default: frame_ch.ready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (rx_ch.valid && rx_ch.ready) || (frame_ch.valid && frame_ch.ready))
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= IDLE_LIMIT)
            begin
                $display("[%0t] no transfer for %0d cycles, %0d results still due",
                         $realtime, IDLE_LIMIT, results_due);
                $display("sync_word_length_deframer_core_tb failed");
                $finish;
            end
        end
    end

    initial
    begin
        int          kind;
        int          n;
        bit          long_done;
        bit          over_done;
        logic [31:0] len;

        rst_n         = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        bytes_sent    = 0;
        long_done     = 1'b0;
        over_done     = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        burst_left = $urandom_range(1, 32);

        // leading junk so the first header is found by sliding the window
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(swld_pkg::SYNC_FIRST);
        send_frame(8'hFF, 32'hFFFF_FFFF, 32'd0, 0);
        send_frame(8'h00, 32'h0000_0000, 32'd1, 1);
        send_frame(8'h5A, 32'h1234_5678, swld_pkg::MAX_LENGTH + 1, 0);
        send_frame(8'($urandom_range(0, 255)), $urandom, 32'h8000_0000, 0);
        send_frame(8'($urandom_range(0, 255)), $urandom, 32'hFFFF_FFFF, 0);
        send_frame(8'($urandom_range(0, 255)), $urandom, 32'd3, 3);
        drain_results();

        // every byte offered counts toward the budget, absorbed ones included
        while (bytes_sent < ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (!long_done && bytes_sent > 160)
            begin
                // largest frame that still fits, with the receiver holding off
                hold_req <= 1'b1;
                send_frame(8'($urandom_range(0, 255)), $urandom, BUF - HDR, BUF - HDR);
                long_done = 1'b1;
            end
            else if (!over_done && bytes_sent > 680)
            begin
                case ($urandom_range(0, 2))
                    0: len = BUF - HDR + 1;
                    1: len = swld_pkg::MAX_LENGTH;
                    default: len = $urandom_range(BUF - HDR + 2, swld_pkg::MAX_LENGTH - 1);
                endcase
                send_frame(8'($urandom_range(0, 255)), $urandom, len, BUF - HDR);
                over_done = 1'b1;
            end
            else if (kind < 60)
            begin
                n = $urandom_range(0, 99);
                if (n < 75)
                    n = $urandom_range(1, 8);
                else if (n < 95)
                    n = $urandom_range(9, 40);
                else
                    n = $urandom_range(41, 120);
                send_frame(8'($urandom_range(0, 255)), $urandom, n, n);
            end
            else if (kind < 68)
            begin
                send_frame(8'($urandom_range(0, 255)), $urandom, 32'd0, 0);
            end
            else if (kind < 76)
            begin
                case ($urandom_range(0, 2))
                    0: len = swld_pkg::MAX_LENGTH + 1;
                    1: len = {1'b1, 31'($urandom)};
                    default: len = $urandom_range(swld_pkg::MAX_LENGTH + 2, 32'h7FFF_FFFF);
                endcase
                send_frame(8'($urandom_range(0, 255)), $urandom, len, 0);
            end
            else if (kind < 86)
            begin
                n = $urandom_range(1, 12);
                repeat (n) send_byte(8'($urandom_range(0, 255)));
            end
            else if (kind < 95)
            begin
                // sync pair followed by a cut-off header
                n = $urandom_range(0, 20);
                send_byte(swld_pkg::SYNC_FIRST);
                send_byte(swld_pkg::SYNC_SECOND);
                repeat (n) send_byte(8'($urandom_range(0, 255)));
            end
            else
                drain_results();
        end

        drain_results();
        repeat (TAIL) @(posedge clk);
        @(negedge clk);
        $display("run: %0d bytes in, %0d results checked, %0d frames ended, %0d of them empty",
                 bytes_sent, results_seen, frames_done, empty_frames);
        $display("run: %0d window slides, %0d rejected lengths, %0d oversize frames absorbed",
                 resyncs, bad_lengths, oversize_frames);
        if (mismatches == 0 && results_due == 0)
            $display("sync_word_length_deframer_core_tb passed");
        else
            $display("sync_word_length_deframer_core_tb failed");
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/swld_pkg.sv
hw/rtl/swld_rx_if.sv
hw/rtl/swld_frame_if.sv
hw/rtl/swld_rx_stage.sv
hw/rtl/swld_parser.sv
hw/rtl/sync_word_length_deframer_core.sv
tb/swld_frame_checker.sv
tb/sync_word_length_deframer_core_tb.sv
